// ----- sv/sst_pkg.sv -----
// shared types, constants and handshake structs of the subresource state tracker
package sst_pkg;

    localparam int MAX_MIPS_DEF   = 16;
    localparam int MAX_LAYERS_DEF = 64;
    localparam int STATE_W        = 4;
    localparam int EPOCH_W        = 6;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_MIPS    = 2'd0;
    localparam logic [1:0] REG_LAYERS  = 2'd1;
    localparam logic [1:0] REG_STENCIL = 2'd2;

    typedef enum logic [1:0] {
        KIND_SET_RANGE   = 2'd0,
        KIND_QUERY       = 2'd1,
        KIND_SET_STENCIL = 2'd2,
        KIND_NONE        = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [3:0]   base_mip;
        logic [4:0]   mip_count;
        logic [5:0]   base_layer;
        logic [6:0]   layer_count;
        logic [3:0]   new_state;
    } t_in_item;

    typedef struct packed {
        logic [3:0]   state_out;
        logic [3:0]   stencil_out;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic whole_apply;
        logic stencil_apply;
        logic walk_step;
        logic q_default;
        logic q_check;
        logic clr_step;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  whole_req;
        logic  in_range;
        logic  walk_empty;
        logic  walk_last;
        logic  clr_last;
        logic  epoch_wrap;
        logic  out_free;
    } t_status;

endpackage

// ----- sv/subresource_state_tracker.sv -----
// top level of the subresource state tracker: apb registers, controller and datapath
//
//  channel   direction  handshake                          payload
//  -------   ---------  ---------------------------------  ---------------------
//  request   in         i_in_valid / o_in_ready            i_in_data (t_in_item)
//  result    out        o_out_valid / i_out_ready          o_out_data (t_out_item)
//  config    in         psel, penable, pwrite / pready     paddr, pwdata, prdata
//
//  query, stencil set, no-op and partial set with empty range: no store write
//  range set: one store write per covered (mip, layer) entry
//  whole-image set: every (2**EPOCH_W - 1)th one adds a wipe of all MAX_MIPS*MAX_LAYERS
//  override store entries, since the epoch tag wraps
//  after reset the whole store is wiped before o_in_ready rises
//  a result waiting in the output register stalls only the end of the next item
module subresource_state_tracker
    import sst_pkg::*;
#(
    parameter int MAX_MIPS   = MAX_MIPS_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration registers
    logic [4:0] r_mips_in_use;
    logic [6:0] r_layers_in_use;
    logic       r_has_stencil;
    logic       cfg_wr;

    // write completes in the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mips_in_use   <= 5'd1;
            r_layers_in_use <= 7'd1;
            r_has_stencil   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MIPS:    r_mips_in_use   <= pwdata[4:0];
                REG_LAYERS:  r_layers_in_use <= pwdata[6:0];
                REG_STENCIL: r_has_stencil   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // read back, unmapped addresses read as zero
    always_comb begin
        case (paddr[3:2])
            REG_MIPS:    prdata = {27'd0, r_mips_in_use};
            REG_LAYERS:  prdata = {25'd0, r_layers_in_use};
            REG_STENCIL: prdata = {31'd0, r_has_stencil};
            default:     prdata = '0;
        endcase
    end

    // controller and datapath talk only through these two structs
    t_cmd    w_cmd;
    t_status w_status;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // item capture, range walk, override store with epoch tags, output register
    sst_dp #(
        .MAX_MIPS   (MAX_MIPS),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_item          (i_in_data),
        .i_mips_in_use   (r_mips_in_use),
        .i_layers_in_use (r_layers_in_use),
        .i_has_stencil   (r_has_stencil),
        .i_out_ready     (i_out_ready),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_data)
    );

    // one item in flight: no transfer right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous item still in flight");

    // the range walk only runs for a partial range set
    a_walk_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.walk_step |-> (w_status.kind == KIND_SET_RANGE) && !w_status.whole_req)
        else $error("store walk outside a partial range set");

    // a new result never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a result shows up only after the controller pushed one
    a_push_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.push))
        else $error("result valid without push");

endmodule

// ----- sv/sst_ram.sv -----
// generic single write port ram with registered read
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sst_ctrl.sv -----
// sequencing state machine of the subresource state tracker
module sst_ctrl
    import sst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_QCHK   = 7'b0010000,
        S_WIPE   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.kind)
                    KIND_SET_RANGE: begin
                        if (i_status.whole_req) begin
                            o_cmd.whole_apply = 1'b1;
                            n_state = i_status.epoch_wrap ? S_WIPE : S_DONE;
                        end else if (i_status.walk_empty) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    KIND_QUERY: begin
                        if (i_status.whole_req || !i_status.in_range) begin
                            o_cmd.q_default = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            n_state = S_QCHK;
                        end
                    end
                    KIND_SET_STENCIL: begin
                        o_cmd.stencil_apply = 1'b1;
                        n_state             = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) n_state = S_DONE;
            end
            S_QCHK: begin
                o_cmd.q_check = 1'b1;
                n_state       = S_DONE;
            end
            S_WIPE: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sst_dp.sv -----
// datapath: item registers, range walker, override store and result register
module sst_dp
    import sst_pkg::*;
#(
    parameter int MAX_MIPS   = MAX_MIPS_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_item   i_item,
    input  logic [4:0] i_mips_in_use,
    input  logic [6:0] i_layers_in_use,
    input  logic       i_has_stencil,
    input  logic       i_out_ready,
    output t_status    o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    localparam int DEPTH = MAX_MIPS * MAX_LAYERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = EPOCH_W + STATE_W;

    // sizes in use, saturated to the maxima, zero taken as one
    logic [4:0] nm;
    logic [6:0] nl;
    logic [5:0] sum_m;
    logic [7:0] sum_l;
    logic       whole_now;
    logic       in_range_now;

    always_comb begin
        if (i_mips_in_use == 5'd0) begin
            nm = 5'd1;
        end else if (int'(i_mips_in_use) > MAX_MIPS) begin
            nm = 5'(MAX_MIPS);
        end else begin
            nm = i_mips_in_use;
        end
        if (i_layers_in_use == 7'd0) begin
            nl = 7'd1;
        end else if (int'(i_layers_in_use) > MAX_LAYERS) begin
            nl = 7'(MAX_LAYERS);
        end else begin
            nl = i_layers_in_use;
        end
    end

    // one bit of headroom so a raw count past the end cannot wrap
    assign sum_m = 6'(i_item.base_mip) + 6'(i_item.mip_count);
    assign sum_l = 8'(i_item.base_layer) + 8'(i_item.layer_count);
    assign whole_now = (i_item.base_mip == 4'd0) && (i_item.mip_count >= nm)
                    && (i_item.base_layer == 6'd0) && (i_item.layer_count >= nl);
    assign in_range_now = (5'(i_item.base_mip) < nm) && (7'(i_item.base_layer) < nl);

    // captured item
    t_kind               r_kind;
    logic [STATE_W-1:0]  r_ns;
    logic [4:0]          r_m;
    logic [4:0]          r_end_m;
    logic [6:0]          r_l;
    logic [6:0]          r_bl;
    logic [6:0]          r_end_l;
    logic                r_whole_req;
    logic                r_in_range;

    logic [6:0] l_next;
    logic       row_end;

    assign l_next  = r_l + 7'd1;
    assign row_end = (l_next == r_end_l);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_item.kind;
            r_ns        <= i_item.new_state;
            r_m         <= 5'(i_item.base_mip);
            r_l         <= 7'(i_item.base_layer);
            r_bl        <= 7'(i_item.base_layer);
            r_end_m     <= (sum_m > 6'(nm)) ? nm : sum_m[4:0];
            r_end_l     <= (sum_l > 8'(nl)) ? nl : sum_l[6:0];
            r_whole_req <= whole_now;
            r_in_range  <= in_range_now;
        end else if (i_cmd.walk_step) begin
            if (row_end) begin
                r_l <= r_bl;
                r_m <= r_m + 5'd1;
            end else begin
                r_l <= l_next;
            end
        end
    end

    // image-wide state and epoch tag
    logic [STATE_W-1:0] r_whole;
    logic [STATE_W-1:0] r_stencil;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_clr_addr;
    logic               clr_last;

    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole    <= '0;
            r_stencil  <= '0;
            r_epoch    <= EPOCH_W'(1);
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.whole_apply) begin
                r_whole   <= r_ns;
                r_stencil <= i_has_stencil ? r_ns : '0;
                r_epoch   <= (&r_epoch) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
            end else if (i_cmd.stencil_apply) begin
                r_stencil <= i_has_stencil ? r_ns : '0;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + AW'(1);
            end
        end
    end

    // override store: {epoch tag, state}, tag zero means no override
    logic [AW-1:0] idx;
    logic          we;
    logic [AW-1:0] waddr;
    logic [RW-1:0] wdata;
    logic [RW-1:0] rdata;

    assign idx   = AW'(r_m) * AW'(MAX_LAYERS) + AW'(r_l);
    assign we    = i_cmd.clr_step | i_cmd.walk_step;
    assign waddr = i_cmd.clr_step ? r_clr_addr : idx;
    assign wdata = (i_cmd.clr_step || (r_ns == r_whole)) ? '0 : {r_epoch, r_ns};

    sst_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (idx),
        .o_rdata (rdata)
    );

    // query result and output register
    logic [STATE_W-1:0] r_qres;
    logic               r_out_valid;
    t_out_item          r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_default) begin
            r_qres <= r_whole;
        end else if (i_cmd.q_check) begin
            r_qres <= (rdata[RW-1:STATE_W] == r_epoch) ? rdata[STATE_W-1:0] : r_whole;
        end
        if (i_cmd.push) begin
            r_out.state_out   <= (r_kind == KIND_QUERY) ? r_qres : r_whole;
            r_out.stencil_out <= r_stencil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.kind       = r_kind;
    assign o_status.whole_req  = r_whole_req;
    assign o_status.in_range   = r_in_range;
    assign o_status.walk_empty = (r_m >= r_end_m) || (r_l >= r_end_l);
    assign o_status.walk_last  = row_end && ((r_m + 5'd1) == r_end_m);
    assign o_status.clr_last   = clr_last;
    assign o_status.epoch_wrap = &r_epoch;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule
